/* sv/sras_pkg.sv */
package sras_pkg;

	// Window and slot geometry. The slot of a frame is its number modulo SLOT_COUNT,
	// which must be a power of two so that the slot is a part-select of the number.
	localparam int WINDOW_SIZE = 4;
	localparam int SLOT_COUNT  = 8;
	localparam int SLOT_W      = $clog2(SLOT_COUNT);
	localparam int MAX_RESULTS = 4;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	// Field widths.
	localparam int FRAME_W = 16;
	localparam int OP_W    = 2;
	localparam int KIND_W  = 2;

	// Reset value of the total frame count register.
	localparam logic [FRAME_W-1:0] TOTAL_RESET = FRAME_W'(10);

	// Event codes on the input channel.
	typedef enum logic [OP_W-1:0] {
		OP_START   = 2'd0,
		OP_ACK     = 2'd1,
		OP_NAK     = 2'd2,
		OP_TIMEOUT = 2'd3
	} op_t;

	// Result kinds on the output channel.
	typedef enum logic [KIND_W-1:0] {
		KIND_NEW    = 2'd0,
		KIND_RESENT = 2'd1,
		KIND_END    = 2'd2
	} kind_t;

	// One result item as it is staged inside the block.
	typedef struct packed {
		kind_t                kind;
		logic [FRAME_W-1:0]   frame_id;
	} result_t;

endpackage

/* sv/selective_repeat_arq_sender_core.sv */
// Selective-repeat ARQ sender core.
// Input channel (in_valid / in_stall, op, frame_number) carries one event:
// start, ack, nak or timeout tick. Output channel (out_valid / out_stall,
// kind, frame_id, last) carries the frames to send, new or resent, and a
// final end marker; last marks the final result of an event. An event may
// cause zero to four results. The user writes the total frame count via
// cfg_we / cfg_wdata only while idle; the block does not enforce this.
//
// One event is handled by a small sequencer that walks the window one slot
// per cycle unless the output stalls. An event is accepted; on an ack the
// base moves past acknowledged slots; a loop then sends new frames or scans
// window slots and is left; the end check and the hand-over of the last
// result follow. When only the end marker goes out, it is handed over
// after the accept; once finished, an event is accepted and dropped.
// in_stall is high for the whole event; the next event is accepted as soon
// as the last result sits in the output register, even if it is not taken.
//
// Reset clears the window base, the next frame number, every outstanding
// bit and the finished flag, and sets the total to ten. A stalled result
// stays in the output register and the sequencer waits; nothing is lost.
module selective_repeat_arq_sender_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [sras_pkg::OP_W-1:0]     op,
	input  logic [sras_pkg::FRAME_W-1:0]  frame_number,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [sras_pkg::KIND_W-1:0]   kind,
	output logic [sras_pkg::FRAME_W-1:0]  frame_id,
	output logic                          last,
	input  logic                          cfg_we,
	input  logic [sras_pkg::FRAME_W-1:0]  cfg_wdata
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADV,
		S_FILL,
		S_TMO,
		S_END,
		S_FLUSH
	} state_t;

	localparam int LIM_W = sras_pkg::FRAME_W + 1;

	state_t                          state_q;
	logic [sras_pkg::FRAME_W-1:0]    total_q;
	logic [sras_pkg::FRAME_W-1:0]    window_base_q;
	logic [sras_pkg::FRAME_W-1:0]    next_new_q;
	logic [sras_pkg::FRAME_W-1:0]    scan_q;
	logic [sras_pkg::SLOT_COUNT-1:0] outstanding_q;
	logic                            finished_q;
	logic [sras_pkg::CNT_W-1:0]      cnt_q;

	// One result waits here until the next one shows whether it was the last.
	logic                            pend_valid_q;
	sras_pkg::result_t               pend_q;

	// Output register.
	logic                            out_valid_q;
	sras_pkg::result_t               out_q;
	logic                            out_last_q;

	logic                            in_xfer;
	logic                            out_free;
	logic                            can_emit;
	logic [LIM_W-1:0]                limit;
	logic [LIM_W-1:0]                base_plus;
	logic                            base_done;
	logic                            cnt_room;
	logic                            fn_in_window;
	logic [sras_pkg::SLOT_W-1:0]     fn_slot;
	logic [sras_pkg::SLOT_W-1:0]     base_slot;
	logic [sras_pkg::SLOT_W-1:0]     new_slot;
	logic [sras_pkg::SLOT_W-1:0]     scan_slot;
	logic                            fill_go;
	logic                            tmo_go;
	logic                            end_go;
	logic                            out_load;

	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign can_emit  = !pend_valid_q || out_free;
	assign cnt_room  = (cnt_q < sras_pkg::CNT_W'(sras_pkg::MAX_RESULTS));
	assign base_done = (window_base_q >= total_q);

	// Slots are the low bits of the frame number.
	assign fn_slot   = frame_number[sras_pkg::SLOT_W-1:0];
	assign base_slot = window_base_q[sras_pkg::SLOT_W-1:0];
	assign new_slot  = next_new_q[sras_pkg::SLOT_W-1:0];
	assign scan_slot = scan_q[sras_pkg::SLOT_W-1:0];

	assign fn_in_window = (frame_number >= window_base_q) && (frame_number < next_new_q);

	// Fill limit: the smaller of base plus window and the total.
	always_comb begin
		base_plus = {1'b0, window_base_q} + LIM_W'(sras_pkg::WINDOW_SIZE);
		if (base_plus > {1'b0, total_q}) begin
			limit = {1'b0, total_q};
		end else begin
			limit = base_plus;
		end
	end

	// Loop conditions of the fill, the timeout scan and the end check.
	assign fill_go = ({1'b0, next_new_q} < limit) && cnt_room && !outstanding_q[new_slot];
	assign tmo_go  = (scan_q < next_new_q) && cnt_room;
	assign end_go  = base_done && cnt_room;

	// A staged result moves into the output register at this edge.
	assign out_load = pend_valid_q && out_free &&
		(((state_q == S_FILL) && fill_go) ||
		 ((state_q == S_TMO) && tmo_go && outstanding_q[scan_slot]) ||
		 ((state_q == S_END) && end_go) ||
		 (state_q == S_FLUSH));

	// Sequencer, window state and result staging.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			total_q       <= sras_pkg::TOTAL_RESET;
			window_base_q <= '0;
			next_new_q    <= '0;
			scan_q        <= '0;
			outstanding_q <= '0;
			finished_q    <= 1'b0;
			cnt_q         <= '0;
			pend_valid_q  <= 1'b0;
			pend_q        <= '0;
			out_valid_q   <= 1'b0;
			out_q         <= '0;
			out_last_q    <= 1'b0;
		end else begin
			// The output register empties once its transfer completes, unless a
			// new result moves in at the same edge.
			if (!out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_we) begin
				total_q <= cfg_wdata;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_xfer && !finished_q) begin
						if (base_done) begin
							// Total already reached: only the end marker goes out.
							finished_q            <= 1'b1;
							pend_valid_q          <= 1'b1;
							pend_q.kind           <= sras_pkg::KIND_END;
							pend_q.frame_id       <= '0;
							cnt_q                 <= sras_pkg::CNT_W'(1);
							state_q               <= S_FLUSH;
						end else begin
							unique case (sras_pkg::op_t'(op))
								sras_pkg::OP_START: begin
									cnt_q   <= '0;
									state_q <= S_FILL;
								end
								sras_pkg::OP_ACK: begin
									if (fn_in_window) begin
										outstanding_q[fn_slot] <= 1'b0;
									end
									cnt_q   <= '0;
									state_q <= S_ADV;
								end
								sras_pkg::OP_NAK: begin
									if (fn_in_window && outstanding_q[fn_slot]) begin
										pend_valid_q    <= 1'b1;
										pend_q.kind     <= sras_pkg::KIND_RESENT;
										pend_q.frame_id <= frame_number;
										cnt_q           <= sras_pkg::CNT_W'(1);
									end else begin
										cnt_q           <= '0;
									end
									state_q <= S_END;
								end
								sras_pkg::OP_TIMEOUT: begin
									cnt_q   <= '0;
									scan_q  <= window_base_q;
									state_q <= S_TMO;
								end
								default: begin
									state_q <= S_IDLE;
								end
							endcase
						end
					end
				end

				// Move the base past acknowledged slots, one slot a cycle.
				S_ADV: begin
					if ((window_base_q < next_new_q) && !outstanding_q[base_slot]) begin
						window_base_q <= window_base_q + 1'b1;
					end else begin
						state_q <= S_FILL;
					end
				end

				// Send new frames up to the limit, one a cycle unless the output stalls.
				S_FILL: begin
					if (fill_go) begin
						if (can_emit) begin
							if (pend_valid_q) begin
								out_valid_q <= 1'b1;
								out_q       <= pend_q;
								out_last_q  <= 1'b0;
							end
							pend_valid_q            <= 1'b1;
							pend_q.kind             <= sras_pkg::KIND_NEW;
							pend_q.frame_id         <= next_new_q;
							cnt_q                   <= cnt_q + 1'b1;
							outstanding_q[new_slot] <= 1'b1;
							next_new_q              <= next_new_q + 1'b1;
						end
					end else begin
						state_q <= S_END;
					end
				end

				// Resend every outstanding frame of the window, one slot a cycle unless the output stalls.
				S_TMO: begin
					if (tmo_go) begin
						if (!outstanding_q[scan_slot]) begin
							scan_q <= scan_q + 1'b1;
						end else if (can_emit) begin
							if (pend_valid_q) begin
								out_valid_q <= 1'b1;
								out_q       <= pend_q;
								out_last_q  <= 1'b0;
							end
							pend_valid_q    <= 1'b1;
							pend_q.kind     <= sras_pkg::KIND_RESENT;
							pend_q.frame_id <= scan_q;
							cnt_q           <= cnt_q + 1'b1;
							scan_q          <= scan_q + 1'b1;
						end
					end else begin
						state_q <= S_END;
					end
				end

				// Append the end marker once the base reaches the total.
				S_END: begin
					if (end_go) begin
						if (can_emit) begin
							if (pend_valid_q) begin
								out_valid_q <= 1'b1;
								out_q       <= pend_q;
								out_last_q  <= 1'b0;
							end
							finished_q      <= 1'b1;
							pend_valid_q    <= 1'b1;
							pend_q.kind     <= sras_pkg::KIND_END;
							pend_q.frame_id <= '0;
							cnt_q           <= cnt_q + 1'b1;
							state_q         <= S_FLUSH;
						end
					end else begin
						state_q <= S_FLUSH;
					end
				end

				// Hand over the final result of the event with last set.
				S_FLUSH: begin
					if (!pend_valid_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						out_valid_q  <= 1'b1;
						out_q        <= pend_q;
						out_last_q   <= 1'b1;
						pend_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = out_q.kind;
	assign frame_id  = out_q.frame_id;
	assign last      = out_last_q;

	// Once finished, the block stays finished until reset.
	a_finished_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |=> finished_q)
		else $error("finished flag cleared without reset");

	// No result is held back while the block waits for an event.
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_valid_q)
		else $error("pending result left behind at end of event");

	// The base never passes the next new frame.
	a_base_order: assert property (@(posedge clk) disable iff (!arst_n)
		window_base_q <= next_new_q)
		else $error("window base beyond next new frame");

	// The window never holds more frames than its size.
	a_window_size: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, next_new_q} - {1'b0, window_base_q}) <= LIM_W'(sras_pkg::WINDOW_SIZE))
		else $error("window wider than its size");

	// No event produces more results than the limit.
	a_result_count: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= sras_pkg::CNT_W'(sras_pkg::MAX_RESULTS))
		else $error("too many results for one event");

endmodule
